/* hdl/ttc_pkg.sv */
// Shared types and fixed field widths for the tile tag cache.
`default_nettype none
package ttc_pkg;

    localparam int ZOOM_W = 6;
    localparam int VIEW_W = 2;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS_RD,
        ST_INS_WR,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hdl/ttc_store.sv */
// Key and handle memory with one write port and one registered read port.
`default_nettype none
module ttc_store #(
    parameter int ENTRIES     = 32,
    parameter int KEY_W       = 50,
    parameter int HANDLE_BITS = 16,
    parameter int IDX_W       = 5
) (
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [IDX_W-1:0]       wr_addr,
    input  wire logic [KEY_W-1:0]       wr_key,
    input  wire logic [HANDLE_BITS-1:0] wr_handle,
    input  wire logic [IDX_W-1:0]       rd_addr,
    output logic      [KEY_W-1:0]       rd_key,
    output logic      [HANDLE_BITS-1:0] rd_handle
);

    logic [KEY_W-1:0]       key_mem    [ENTRIES];
    logic [HANDLE_BITS-1:0] handle_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]    <= wr_key;
            handle_mem[wr_addr] <= wr_handle;
        end
    end

    // Read data is registered; a write in the same cycle returns the old entry.
    always_ff @(posedge clk)
    begin
        rd_key    <= key_mem[rd_addr];
        rd_handle <= handle_mem[rd_addr];
    end

endmodule
`default_nettype wire

/* hdl/tile_tag_cache_fifo.sv */
// Lookup walks the store one entry per cycle through a single key comparator.
// One item is in work at a time; the next is accepted in the cycle after the result is
// loaded, and loading the result waits while a held result is not yet taken.
// Reset clears all valid marks and the ring pointer at once; the key and
// handle stores are not cleared and need no clearing pass.
`default_nettype none
module tile_tag_cache_fifo #(
    parameter int ENTRIES     = 32,
    parameter int COORD_BITS  = 21,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [COORD_BITS-1:0]            tile_col,
    input  wire logic [COORD_BITS-1:0]            tile_row,
    input  wire logic signed [ttc_pkg::ZOOM_W-1:0] zoom_level,
    input  wire logic [ttc_pkg::VIEW_W-1:0]       view_kind,
    input  wire logic [HANDLE_BITS-1:0]           new_handle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic      [HANDLE_BITS-1:0]           found_handle,
    output logic                                  evicted_valid,
    output logic      [HANDLE_BITS-1:0]           evicted_handle
);

    import ttc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int KEY_W = 2 * COORD_BITS + ZOOM_W + VIEW_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    logic [ENTRIES-1:0]     valid_marks_reg, valid_marks_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   chk_vld_reg, chk_vld_next;
    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic                   res_hit_reg, res_hit_next;
    logic [HANDLE_BITS-1:0] res_found_reg, res_found_next;
    logic                   res_ev_reg, res_ev_next;
    logic [HANDLE_BITS-1:0] res_ev_handle_reg, res_ev_handle_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg;
    logic [HANDLE_BITS-1:0] out_found_reg;
    logic                   out_ev_reg;
    logic [HANDLE_BITS-1:0] out_ev_handle_reg;

    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;

    logic accept;
    logic issue;
    logic match;
    logic scan_finish;
    logic out_load;
    logic wr_en;

    assign accept = in_valid && in_ready;
    assign match  = chk_vld_reg && valid_marks_reg[chk_idx_reg] && (rd_key == key_reg);

    ttc_store #(
        .ENTRIES     (ENTRIES),
        .KEY_W       (KEY_W),
        .HANDLE_BITS (HANDLE_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (ptr_reg),
        .wr_key    (key_reg),
        .wr_handle (handle_reg),
        .rd_addr   (idx_reg),
        .rd_key    (rd_key),
        .rd_handle (rd_handle)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(command) == CMD_INSERT)
                        state_next = ST_INS_RD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_finish)
                    state_next = ST_DONE;
            end
            ST_INS_RD:
                state_next = ST_INS_WR;
            ST_INS_WR:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready    = 1'b0;
        issue       = 1'b0;
        scan_finish = 1'b0;
        out_load    = 1'b0;
        wr_en       = 1'b0;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_SCAN:
            begin
                scan_finish = match || (chk_vld_reg && (chk_idx_reg == LAST_IDX));
                issue       = !scan_finish;
            end
            ST_INS_RD:
                in_ready = 1'b0;
            ST_INS_WR:
                wr_en = 1'b1;
            ST_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        idx_next           = idx_reg;
        chk_vld_next       = issue;
        ptr_next           = ptr_reg;
        valid_marks_next   = valid_marks_reg;
        res_hit_next       = res_hit_reg;
        res_found_next     = res_found_reg;
        res_ev_next        = res_ev_reg;
        res_ev_handle_next = res_ev_handle_reg;
        out_valid_next     = out_valid_reg;

        if (accept)
        begin
            idx_next           = (cmd_t'(command) == CMD_INSERT) ? ptr_reg : '0;
            res_hit_next       = 1'b0;
            res_found_next     = '0;
            res_ev_next        = 1'b0;
            res_ev_handle_next = '0;
        end
        else if (issue)
        begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end

        if (scan_finish && match)
        begin
            res_hit_next   = 1'b1;
            res_found_next = rd_handle;
        end

        if (wr_en)
        begin
            res_ev_next               = valid_marks_reg[ptr_reg];
            res_ev_handle_next        = valid_marks_reg[ptr_reg] ? rd_handle : '0;
            valid_marks_next[ptr_reg] = 1'b1;
            ptr_next                  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_marks_reg <= '0;
            ptr_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_marks_reg <= valid_marks_next;
            ptr_reg         <= ptr_next;
            chk_vld_reg     <= chk_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        chk_idx_reg       <= idx_reg;
        res_hit_reg       <= res_hit_next;
        res_found_reg     <= res_found_next;
        res_ev_reg        <= res_ev_next;
        res_ev_handle_reg <= res_ev_handle_next;
        if (accept)
        begin
            key_reg    <= {tile_col, tile_row, zoom_level, view_kind};
            handle_reg <= new_handle;
        end
        if (out_load)
        begin
            out_hit_reg       <= res_hit_reg;
            out_found_reg     <= res_found_reg;
            out_ev_reg        <= res_ev_reg;
            out_ev_handle_reg <= res_ev_handle_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign found_handle   = out_found_reg;
    assign evicted_valid  = out_ev_reg;
    assign evicted_handle = out_ev_handle_reg;

endmodule
`default_nettype wire
